### rtl/spw_pkg.sv
// types, constants and tables shared by the swirl pixel warp modules
`timescale 1ns / 1ps

package spw_pkg;

    // fixed-point widths
    localparam int SQRT_STEPS   = 17;   // result bits of the distance square root
    localparam int CORDIC_STEPS = 15;
    localparam int REM_W        = 34;   // sqrt remainder, holds d2 << 12
    localparam int RES_W        = 35;   // sqrt partial root plus trial bit
    localparam int DIST_W       = 17;   // distance, Q11.6
    localparam int VX_W         = 28;   // vectoring x/y, pixel offsets scaled by 2^14
    localparam int RX_W         = 18;   // rotation x/y, Q2.14 plus growth
    localparam int ANG_W        = 18;   // angles, 14 fraction bits, signed
    localparam int WRAP_W       = 26;   // unsigned angle before the modulo
    localparam int QUOT_W       = 10;   // turns removed by the modulo

    localparam logic signed [ANG_W-1:0] ANG_PI      = 18'sd51472;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 18'sd25736;
    localparam logic [WRAP_W-1:0] WRAP_MOD   = 26'd102944;  // two pi
    localparam logic [WRAP_W-1:0] WRAP_OFS   = 26'd154416;  // three pi, keeps sum positive
    localparam logic [15:0]       WRAP_RECIP = 16'd41721;   // floor(2^32 / two pi)
    localparam int                WRAP_SHIFT = 32;
    localparam logic signed [RX_W-1:0] CORDIC_GAIN_INV = 18'sd9949;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CENTER_X   = 3'd0,
        CFG_CENTER_Y   = 3'd1,
        CFG_BOX_WIDTH  = 3'd2,
        CFG_BOX_HEIGHT = 3'd3,
        CFG_TWIST_RATE = 3'd4
    } spw_cfg_idx_t;

    localparam logic [15:0] TWIST_RATE_RESET = 16'd3277;

    typedef struct packed {
        logic [9:0]  pixel_x;
        logic [9:0]  pixel_y;
        logic [23:0] pixel_color;
    } spw_in_t;

    typedef struct packed {
        logic signed [11:0] write_x;
        logic signed [11:0] write_y;
        logic [23:0]        write_color;
        logic               inside_swirl;
        logic               in_frame;
    } spw_out_t;

    // square root cell state
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [RES_W-1:0] res;
    } spw_sqrt_t;

    // cordic cell states
    typedef struct packed {
        logic signed [VX_W-1:0]  x;
        logic signed [VX_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } spw_vec_t;

    typedef struct packed {
        logic signed [RX_W-1:0]  x;
        logic signed [RX_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } spw_rot_t;

    // per-item data riding along the pipe
    typedef struct packed {
        logic [9:0]        pixel_x;
        logic [9:0]        pixel_y;
        logic [23:0]       pixel_color;
        logic              in_swirl;
        logic              on_center;
        logic              flip;
        logic [DIST_W-1:0] dist_q;
    } spw_side_t;

    // atan(2^-i) in Q2.14, rounded
    function automatic logic signed [ANG_W-1:0] atan_step(input int i);
        logic signed [ANG_W-1:0] a;
        case (i)
            0:  a = 18'sd12868;
            1:  a = 18'sd7596;
            2:  a = 18'sd4014;
            3:  a = 18'sd2037;
            4:  a = 18'sd1023;
            5:  a = 18'sd512;
            6:  a = 18'sd256;
            7:  a = 18'sd128;
            8:  a = 18'sd64;
            9:  a = 18'sd32;
            10: a = 18'sd16;
            11: a = 18'sd8;
            12: a = 18'sd4;
            13: a = 18'sd2;
            14: a = 18'sd1;
            default: a = 18'sd0;
        endcase
        return a;
    endfunction

endpackage

### rtl/spw_sqrt_cell.sv
// one bit of the restoring integer square root
`timescale 1ns / 1ps

module spw_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              en,
    input  spw_pkg::spw_sqrt_t cur,
    output spw_pkg::spw_sqrt_t nxt
);
    import spw_pkg::*;

    localparam logic [RES_W-1:0] TRIAL_BIT = RES_W'(1) << (2 * (SQRT_STEPS - 1 - STEP));

    spw_sqrt_t        nxt_reg;
    spw_sqrt_t        nxt_next;
    logic [RES_W-1:0] trial;

    always_comb
    begin
        trial = cur.res + TRIAL_BIT;
        if ({1'b0, cur.rem} >= trial)
        begin
            nxt_next.rem = cur.rem - trial[REM_W-1:0];
            nxt_next.res = (cur.res >> 1) + TRIAL_BIT;
        end
        else
        begin
            nxt_next.rem = cur.rem;
            nxt_next.res = cur.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxt_reg <= nxt_next;
        end
    end

    assign nxt = nxt_reg;

endmodule

### rtl/spw_vec_cell.sv
// one cordic vectoring micro-rotation toward the x axis
`timescale 1ns / 1ps

module spw_vec_cell #(
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic             en,
    input  spw_pkg::spw_vec_t cur,
    output spw_pkg::spw_vec_t nxt
);
    import spw_pkg::*;

    spw_vec_t               nxt_reg;
    spw_vec_t               nxt_next;
    logic signed [VX_W-1:0] xs;
    logic signed [VX_W-1:0] ys;

    always_comb
    begin
        xs = cur.x >>> STEP;
        ys = cur.y >>> STEP;
        if (cur.y > 0)
        begin
            nxt_next.x = cur.x + ys;
            nxt_next.y = cur.y - xs;
            nxt_next.z = cur.z + atan_step(STEP);
        end
        else
        begin
            nxt_next.x = cur.x - ys;
            nxt_next.y = cur.y + xs;
            nxt_next.z = cur.z - atan_step(STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxt_reg <= nxt_next;
        end
    end

    assign nxt = nxt_reg;

endmodule

### rtl/spw_rot_cell.sv
// one cordic rotation micro-step driving the angle to zero
`timescale 1ns / 1ps

module spw_rot_cell #(
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic             en,
    input  spw_pkg::spw_rot_t cur,
    output spw_pkg::spw_rot_t nxt
);
    import spw_pkg::*;

    spw_rot_t               nxt_reg;
    spw_rot_t               nxt_next;
    logic signed [RX_W-1:0] xs;
    logic signed [RX_W-1:0] ys;

    always_comb
    begin
        xs = cur.x >>> STEP;
        ys = cur.y >>> STEP;
        if (cur.z >= 0)
        begin
            nxt_next.x = cur.x - ys;
            nxt_next.y = cur.y + xs;
            nxt_next.z = cur.z - atan_step(STEP);
        end
        else
        begin
            nxt_next.x = cur.x + ys;
            nxt_next.y = cur.y - xs;
            nxt_next.z = cur.z + atan_step(STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxt_reg <= nxt_next;
        end
    end

    assign nxt = nxt_reg;

endmodule

### rtl/swirl_pixel_warp.sv
// top level of the swirl pixel warp: config registers, pipeline and cell chains
`timescale 1ns / 1ps

// Swirl pixel warp. Every pixel item (column, row, color) yields exactly one
// write item. A pixel closer to the configured box center than
// sqrt(box_width^2 + box_height^2) / 5 is moved to
// center + d * (cos, sin)(atan2(dy, dx) + d * twist_rate), truncated toward
// zero; any other pixel is written in place. in_frame reports whether the
// target lies inside an IMAGE_WIDTH x IMAGE_HEIGHT image; targets are never
// clamped. The block takes one pixel item per clock while the pipe is not
// held and delivers results in order. The pipeline is a 17-cell square root
// chain running beside a 15-cell cordic vectoring chain (base angle), a
// five-stage twist and modulo-two-pi section, a 15-cell cordic rotation chain
// (cos, sin) and two multiply/offset stages ending in the output register.
// The whole pipe advances together and holds only while the output register
// is full and not taken. Configuration registers must be written only while
// no item is in flight.
module swirl_pixel_warp #(
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480
) (
    input  logic             clk,
    input  logic             rst_n,
    // configuration write port
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    // pixel items in
    input  logic             pix_valid,
    output logic             pix_ready,
    input  spw_pkg::spw_in_t pix,
    // write items out
    output logic             wr_valid,
    input  logic             wr_ready,
    output spw_pkg::spw_out_t wr
);
    import spw_pkg::*;

    localparam int CHAIN_LEN = SQRT_STEPS;

    // ---------------- configuration registers ----------------
    logic [9:0]  center_x_reg;
    logic [9:0]  center_y_reg;
    logic [9:0]  box_width_reg;
    logic [9:0]  box_height_reg;
    logic [15:0] twist_rate_reg;
    logic [20:0] radius_sq_reg;     // box_width^2 + box_height^2, follows config

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            box_width_reg  <= '0;
            box_height_reg <= '0;
            twist_rate_reg <= TWIST_RATE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER_X:   center_x_reg   <= cfg_data[9:0];
                CFG_CENTER_Y:   center_y_reg   <= cfg_data[9:0];
                CFG_BOX_WIDTH:  box_width_reg  <= cfg_data[9:0];
                CFG_BOX_HEIGHT: box_height_reg <= cfg_data[9:0];
                CFG_TWIST_RATE: twist_rate_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        radius_sq_reg <= 21'(box_width_reg * box_width_reg)
                       + 21'(box_height_reg * box_height_reg);
    end

    // ---------------- global advance ----------------
    logic adv;
    logic out_valid_reg;

    // whole pipe moves unless a finished item sits unclaimed at the output
    assign adv       = !out_valid_reg || wr_ready;
    assign pix_ready = adv;

    // ---------------- stage 1: offsets, squares, vectoring pre-rotation ----------------
    logic                   s1_valid_reg;
    spw_side_t              s1_side_reg;
    logic [19:0]            s1_dxx_reg;
    logic [19:0]            s1_dyy_reg;
    spw_vec_t               s1_vec_reg;

    logic signed [10:0]     dx;
    logic signed [10:0]     dy;
    logic signed [VX_W-1:0] xe;
    logic signed [VX_W-1:0] ye;
    spw_vec_t               vec_init;
    spw_side_t              s1_side_next;

    always_comb
    begin
        dx = $signed({1'b0, pix.pixel_x}) - $signed({1'b0, center_x_reg});
        dy = $signed({1'b0, pix.pixel_y}) - $signed({1'b0, center_y_reg});
        xe = VX_W'(dx) <<< 14;
        ye = VX_W'(dy) <<< 14;
        // quarter turn so the vectoring starts in the right half plane
        if (xe < 0)
        begin
            if (ye >= 0)
            begin
                vec_init.x = ye;
                vec_init.y = -xe;
                vec_init.z = ANG_HALF_PI;
            end
            else
            begin
                vec_init.x = -ye;
                vec_init.y = xe;
                vec_init.z = -ANG_HALF_PI;
            end
        end
        else
        begin
            vec_init.x = xe;
            vec_init.y = ye;
            vec_init.z = '0;
        end
        s1_side_next.pixel_x     = pix.pixel_x;
        s1_side_next.pixel_y     = pix.pixel_y;
        s1_side_next.pixel_color = pix.pixel_color;
        s1_side_next.in_swirl    = 1'b0;
        s1_side_next.on_center   = (dx == 0) && (dy == 0);
        s1_side_next.flip        = 1'b0;
        s1_side_next.dist_q      = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_side_reg <= s1_side_next;
            s1_dxx_reg  <= 20'(dx * dx);
            s1_dyy_reg  <= 20'(dy * dy);
            s1_vec_reg  <= vec_init;
        end
    end

    // ---------------- stage 2: squared distance and inside test ----------------
    logic      cv_valid [CHAIN_LEN+1];
    spw_side_t cv_side  [CHAIN_LEN+1];
    spw_sqrt_t sq       [CHAIN_LEN+1];
    spw_vec_t  vc       [CHAIN_LEN+1];

    logic [20:0] d2;
    logic [26:0] d2_x25;
    spw_side_t   s2_side_next;

    always_comb
    begin
        d2     = {1'b0, s1_dxx_reg} + {1'b0, s1_dyy_reg};
        d2_x25 = (27'(d2) << 4) + (27'(d2) << 3) + 27'(d2);
        s2_side_next          = s1_side_reg;
        s2_side_next.in_swirl = d2_x25 < 27'(radius_sq_reg);
    end

    spw_sqrt_t s2_sqrt_reg;
    spw_vec_t  s2_vec_reg;
    spw_side_t s2_side_reg;
    logic      s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sqrt_reg.rem <= REM_W'(d2) << 12;
            s2_sqrt_reg.res <= '0;
            s2_vec_reg      <= s1_vec_reg;
            s2_side_reg     <= s2_side_next;
        end
    end

    assign cv_valid[0] = s2_valid_reg;
    assign cv_side[0]  = s2_side_reg;
    assign sq[0]       = s2_sqrt_reg;
    assign vc[0]       = s2_vec_reg;

    // ---------------- square root and vectoring chains side by side ----------------
    for (genvar k = 0; k < CHAIN_LEN; k++)
    begin : g_front
        logic      valid_reg;
        spw_side_t side_reg;

        spw_sqrt_cell #(.STEP(k)) u_sqrt (
            .clk (clk),
            .en  (adv),
            .cur (sq[k]),
            .nxt (sq[k+1])
        );

        if (k < CORDIC_STEPS)
        begin : g_vec
            spw_vec_cell #(.STEP(k)) u_vec (
                .clk (clk),
                .en  (adv),
                .cur (vc[k]),
                .nxt (vc[k+1])
            );
        end
        else
        begin : g_vec_hold
            // vectoring is done; keep the angle in step with the root
            spw_vec_t hold_reg;
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    hold_reg <= vc[k];
                end
            end
            assign vc[k+1] = hold_reg;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg <= cv_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg <= cv_side[k];
            end
        end

        assign cv_valid[k+1] = valid_reg;
        assign cv_side[k+1]  = side_reg;
    end

    // ---------------- twist: d * rate, then wrap into [-pi, pi) ----------------
    logic                    t1_valid_reg, t2_valid_reg, t3_valid_reg, t4_valid_reg;
    logic                    t5_valid_reg;
    spw_side_t               t1_side_reg, t2_side_reg, t3_side_reg, t4_side_reg;
    spw_side_t               t5_side_reg;
    logic [32:0]             t1_prod_reg;
    logic signed [ANG_W-1:0] t1_base_reg;
    logic [WRAP_W-1:0]       t2_sum_reg;
    logic [WRAP_W-1:0]       t3_sum_reg;
    logic [QUOT_W-1:0]       t3_quot_reg;
    logic [17:0]             t4_rem_reg;
    logic signed [ANG_W-1:0] t5_ang_reg;

    spw_side_t               t1_side_next;
    logic signed [26:0]      wrap_sum;
    logic [41:0]             recip_prod;
    logic [WRAP_W-1:0]       quot_mul;
    logic [17:0]             rem_fix;
    logic signed [18:0]      ang_wide;

    always_comb
    begin
        t1_side_next        = cv_side[CHAIN_LEN];
        t1_side_next.dist_q = sq[CHAIN_LEN].res[DIST_W-1:0];
        // three pi keeps the sum positive; the extra pi is taken off after the modulo
        wrap_sum   = $signed({2'b00, t1_prod_reg[32:8]}) + 27'(t1_base_reg)
                   + $signed({1'b0, WRAP_OFS});
        recip_prod = 42'(t2_sum_reg) * 42'(WRAP_RECIP);
        quot_mul   = WRAP_W'(t3_quot_reg * WRAP_MOD);
        // quotient estimate may be one short
        rem_fix    = (t4_rem_reg >= 18'(WRAP_MOD)) ? t4_rem_reg - 18'(WRAP_MOD) : t4_rem_reg;
        ang_wide   = $signed({1'b0, rem_fix}) - 19'(ANG_PI);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
            t4_valid_reg <= 1'b0;
            t5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t1_valid_reg <= cv_valid[CHAIN_LEN];
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= t2_valid_reg;
            t4_valid_reg <= t3_valid_reg;
            t5_valid_reg <= t4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_side_reg <= t1_side_next;
            t1_prod_reg <= 33'(t1_side_next.dist_q * twist_rate_reg);
            t1_base_reg <= cv_side[CHAIN_LEN].on_center ? '0 : vc[CHAIN_LEN].z;

            t2_side_reg <= t1_side_reg;
            t2_sum_reg  <= wrap_sum[WRAP_W-1:0];

            t3_side_reg <= t2_side_reg;
            t3_sum_reg  <= t2_sum_reg;
            t3_quot_reg <= recip_prod[WRAP_SHIFT +: QUOT_W];

            t4_side_reg <= t3_side_reg;
            t4_rem_reg  <= 18'(t3_sum_reg - quot_mul);

            t5_side_reg <= t4_side_reg;
            t5_ang_reg  <= ang_wide[ANG_W-1:0];
        end
    end

    // ---------------- rotation: fold into [-pi/2, pi/2], then cordic ----------------
    logic      rv_valid [CORDIC_STEPS+1];
    spw_side_t rv_side  [CORDIC_STEPS+1];
    spw_rot_t  rc       [CORDIC_STEPS+1];

    spw_rot_t  rot_init;
    logic      rot_flip;
    spw_side_t t6_side_next;

    always_comb
    begin
        rot_init.x = CORDIC_GAIN_INV;
        rot_init.y = '0;
        rot_flip   = 1'b1;
        if (t5_ang_reg > ANG_HALF_PI)
        begin
            rot_init.z = t5_ang_reg - ANG_PI;
        end
        else if (t5_ang_reg < -ANG_HALF_PI)
        begin
            rot_init.z = t5_ang_reg + ANG_PI;
        end
        else
        begin
            rot_init.z = t5_ang_reg;
            rot_flip   = 1'b0;
        end
        t6_side_next      = t5_side_reg;
        t6_side_next.flip = rot_flip;
    end

    logic      t6_valid_reg;
    spw_side_t t6_side_reg;
    spw_rot_t  t6_rot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t6_valid_reg <= t5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t6_side_reg <= t6_side_next;
            t6_rot_reg  <= rot_init;
        end
    end

    assign rv_valid[0] = t6_valid_reg;
    assign rv_side[0]  = t6_side_reg;
    assign rc[0]       = t6_rot_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_rot
        logic      valid_reg;
        spw_side_t side_reg;

        spw_rot_cell #(.STEP(k)) u_rot (
            .clk (clk),
            .en  (adv),
            .cur (rc[k]),
            .nxt (rc[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg <= rv_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg <= rv_side[k];
            end
        end

        assign rv_valid[k+1] = valid_reg;
        assign rv_side[k+1]  = side_reg;
    end

    // ---------------- offsets: d * cos, d * sin ----------------
    logic                   m1_valid_reg;
    spw_side_t              m1_side_reg;
    logic signed [35:0]     m1_px_reg;
    logic signed [35:0]     m1_py_reg;

    logic signed [RX_W-1:0] cos_v;
    logic signed [RX_W-1:0] sin_v;
    logic signed [RX_W:0]   dist_s;

    always_comb
    begin
        cos_v  = rv_side[CORDIC_STEPS].flip ? -rc[CORDIC_STEPS].x : rc[CORDIC_STEPS].x;
        sin_v  = rv_side[CORDIC_STEPS].flip ? -rc[CORDIC_STEPS].y : rc[CORDIC_STEPS].y;
        dist_s = $signed({2'b00, rv_side[CORDIC_STEPS].dist_q});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_valid_reg <= rv_valid[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_side_reg <= rv_side[CORDIC_STEPS];
            m1_px_reg   <= 36'(dist_s * 19'(cos_v));
            m1_py_reg   <= 36'(dist_s * 19'(sin_v));
        end
    end

    // ---------------- output: truncate, add center, frame check ----------------
    spw_out_t           out_reg;
    spw_out_t           out_next;
    logic signed [15:0] off_x;
    logic signed [15:0] off_y;
    logic signed [13:0] tgt_x;
    logic signed [13:0] tgt_y;

    always_comb
    begin
        // truncate the Q.20 products toward zero
        off_x = 16'(m1_px_reg >>> 20);
        if (m1_px_reg < 0 && m1_px_reg[19:0] != '0)
        begin
            off_x = off_x + 16'sd1;
        end
        off_y = 16'(m1_py_reg >>> 20);
        if (m1_py_reg < 0 && m1_py_reg[19:0] != '0)
        begin
            off_y = off_y + 16'sd1;
        end

        if (m1_side_reg.in_swirl)
        begin
            tgt_x = $signed({4'b0, center_x_reg}) + 14'(off_x);
            tgt_y = $signed({4'b0, center_y_reg}) + 14'(off_y);
        end
        else
        begin
            tgt_x = $signed({4'b0, m1_side_reg.pixel_x});
            tgt_y = $signed({4'b0, m1_side_reg.pixel_y});
        end

        out_next.write_x      = tgt_x[11:0];
        out_next.write_y      = tgt_y[11:0];
        out_next.write_color  = m1_side_reg.pixel_color;
        out_next.inside_swirl = m1_side_reg.in_swirl;
        out_next.in_frame     = (tgt_x >= 0) && (tgt_x < $signed(14'(IMAGE_WIDTH)))
                             && (tgt_y >= 0) && (tgt_y < $signed(14'(IMAGE_HEIGHT)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign wr_valid = out_valid_reg;
    assign wr       = out_reg;

endmodule

### tb/testbench.sv
// self-checking testbench for the swirl pixel warp
`timescale 1ns / 1ps

module testbench;
    import spw_pkg::*;

    localparam int IMG_W       = 640;
    localparam int IMG_H       = 480;
    localparam int LATENCY     = 42;
    localparam int WATCHDOG    = 4000;
    localparam int N_RANDOM    = 1900;

    // angle constants, 14 fraction bits
    localparam longint A_PI      = 51472;
    localparam longint A_HALF_PI = 25736;
    localparam longint A_TWO_PI  = 102944;
    localparam longint GAIN_INV  = 9949;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        pix_valid;
    logic        pix_ready;
    spw_in_t     pix;
    logic        wr_valid;
    logic        wr_ready;
    spw_out_t    wr;

    swirl_pixel_warp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .wr_valid  (wr_valid),
        .wr_ready  (wr_ready),
        .wr        (wr)
    );

    // clock, 12 ns period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // predictor copy of the registers
    longint     m_cx, m_cy, m_bw, m_bh, m_rate;

    spw_in_t    pixel_queue[$];   // pixels waiting to be driven
    spw_out_t   write_queue[$];   // predicted writes, oldest first
    int         send_idle_pct;    // chance in a hundred the sender idles
    int         recv_stall_pct;   // chance in a hundred the receiver stalls
    int         errors;
    int         idle_cycles;
    int         pixels_sent;
    int         writes_seen;
    int         inside_seen;
    int         outframe_seen;
    bit         cfg_req;
    logic [2:0] cfg_req_idx;
    logic [15:0] cfg_req_val;

    // arithmetic shift right rounding down
    function automatic longint shr_floor(longint v, int s);
        return v >= 0 ? (v >>> s) : ~((~v) >>> s);
    endfunction

    function automatic longint atan_entry(int i);
        longint t[15] = '{12868, 7596, 4014, 2037, 1023, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
        return t[i];
    endfunction

    // integer square root, floor
    function automatic longint root_floor(longint v);
        longint res, bit_w;
        res = 0;
        bit_w = 64'sh1 << 62;
        while (bit_w > v)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (v >= res + bit_w)
            begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end
            else
                res = res >> 1;
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // vectoring cordic, angle of (dx, dy)
    function automatic longint vector_angle(longint dx, longint dy);
        longint x, y, z, t, xs, ys;
        x = dx * 16384;
        y = dy * 16384;
        z = 0;
        if (dx == 0 && dy == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = A_HALF_PI;
            end
            else
            begin
                x = -y;
                y = t;
                z = -A_HALF_PI;
            end
        end
        for (int i = 0; i < 15; i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_entry(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_entry(i);
            end
        end
        return z;
    endfunction

    // rotation cordic, cos and sin of a in [-pi, pi)
    function automatic void rotate_unit(input longint a, output longint c, output longint s);
        longint x, y, z, xs, ys;
        bit neg;
        x = GAIN_INV;
        y = 0;
        z = a;
        neg = 1'b0;
        if (z > A_HALF_PI)
        begin
            z = z - A_PI;
            neg = 1'b1;
        end
        else if (z < -A_HALF_PI)
        begin
            z = z + A_PI;
            neg = 1'b1;
        end
        for (int i = 0; i < 15; i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_entry(i);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_entry(i);
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic longint trunc_q20(longint p);
        return p >= 0 ? (p >>> 20) : -((-p) >>> 20);
    endfunction

    // expected write for one pixel under the current registers
    function automatic spw_out_t warp_pixel(spw_in_t p);
        spw_out_t o;
        longint dx, dy, d2, r2, wx, wy, d, a, c, s;
        bit in_swirl;
        dx = longint'(p.pixel_x) - m_cx;
        dy = longint'(p.pixel_y) - m_cy;
        d2 = dx * dx + dy * dy;
        r2 = m_bw * m_bw + m_bh * m_bh;
        wx = p.pixel_x;
        wy = p.pixel_y;
        in_swirl = (25 * d2) < r2;
        if (in_swirl)
        begin
            d = root_floor(d2 << 12);
            a = vector_angle(dx, dy) + ((d * m_rate) >>> 8);
            a = ((a + A_PI) % A_TWO_PI + A_TWO_PI) % A_TWO_PI - A_PI;
            rotate_unit(a, c, s);
            wx = m_cx + trunc_q20(d * c);
            wy = m_cy + trunc_q20(d * s);
        end
        o.write_x      = wx[11:0];
        o.write_y      = wy[11:0];
        o.write_color  = p.pixel_color;
        o.inside_swirl = in_swirl;
        o.in_frame     = (wx >= 0 && wx < IMG_W && wy >= 0 && wy < IMG_H);
        return o;
    endfunction

    // driver: issues requested config writes, pops pending pixels, holds valid until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid <= 1'b0;
            pix       <= '0;
            cfg_we    <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else
        begin
            cfg_we <= 1'b0;
            if (cfg_req)
            begin
                // the predictor is updated as cfg_we is raised, before the register takes the write
                cfg_we    <= 1'b1;
                cfg_index <= cfg_req_idx;
                cfg_data  <= cfg_req_val;
            end
            if (!pix_valid || pix_ready)
            begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    spw_in_t p;
                    p = pixel_queue.pop_front();
                    write_queue.push_back(warp_pixel(p));
                    pix       <= p;
                    pix_valid <= 1'b1;
                end
                else
                    pix_valid <= 1'b0;
            end
        end
    end

    // monitor: compares each accepted write with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ready      <= 1'b0;
            idle_cycles   <= 0;
            errors        <= 0;
            pixels_sent   <= 0;
            writes_seen   <= 0;
            inside_seen   <= 0;
            outframe_seen <= 0;
        end
        else
        begin
            wr_ready <= ($urandom_range(99) >= recv_stall_pct);
            if ((pix_valid && pix_ready) || (wr_valid && wr_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (pix_valid && pix_ready)
                pixels_sent <= pixels_sent + 1;
            if (wr_valid && wr_ready)
            begin
                writes_seen <= writes_seen + 1;
                if (write_queue.size() == 0)
                begin
                    $error("write item with no pixel pending");
                    errors <= errors + 1;
                end
                else
                begin
                    spw_out_t e;
                    int       bad;
                    e = write_queue.pop_front();
                    bad = 0;
                    if (e.inside_swirl)
                        inside_seen <= inside_seen + 1;
                    if (!e.in_frame)
                        outframe_seen <= outframe_seen + 1;
                    if (wr.write_x !== e.write_x)
                    begin
                        $error("write_x expected %0d got %0d", e.write_x, wr.write_x);
                        bad = bad + 1;
                    end
                    if (wr.write_y !== e.write_y)
                    begin
                        $error("write_y expected %0d got %0d", e.write_y, wr.write_y);
                        bad = bad + 1;
                    end
                    if (wr.write_color !== e.write_color)
                    begin
                        $error("write_color expected %h got %h", e.write_color, wr.write_color);
                        bad = bad + 1;
                    end
                    if (wr.inside_swirl !== e.inside_swirl)
                    begin
                        $error("inside_swirl expected %b got %b", e.inside_swirl,
                               wr.inside_swirl);
                        bad = bad + 1;
                    end
                    if (wr.in_frame !== e.in_frame)
                    begin
                        $error("in_frame expected %b got %b", e.in_frame, wr.in_frame);
                        bad = bad + 1;
                    end
                    errors <= errors + bad;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog: no progress, %0d writes pending", write_queue.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // wait until the pipe is empty, then let it settle
    task automatic drain();
        while (pixel_queue.size() > 0 || pix_valid || write_queue.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // register write, one clock, between phases only
    task automatic write_reg(spw_cfg_idx_t idx, int val);
        cfg_req_idx = idx;
        cfg_req_val = val[15:0];
        cfg_req     = 1'b1;
        @(posedge clk);
        #1;
        cfg_req     = 1'b0;
        case (idx)
            CFG_CENTER_X:   m_cx   = val & 10'h3FF;
            CFG_CENTER_Y:   m_cy   = val & 10'h3FF;
            CFG_BOX_WIDTH:  m_bw   = val & 10'h3FF;
            CFG_BOX_HEIGHT: m_bh   = val & 10'h3FF;
            CFG_TWIST_RATE: m_rate = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic set_box(int cx, int cy, int bw, int bh, int rate);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_BOX_WIDTH, bw);
        write_reg(CFG_BOX_HEIGHT, bh);
        write_reg(CFG_TWIST_RATE, rate);
    endtask

    task automatic add_pixel(int x, int y, int color);
        spw_in_t p;
        p.pixel_x     = x[9:0];
        p.pixel_y     = y[9:0];
        p.pixel_color = color[23:0];
        pixel_queue.push_back(p);
    endtask

    // pixels mostly near the box center, in a square that covers the swirl
    task automatic add_random(int n);
        int rx, ry;
        for (int i = 0; i < n; i++)
        begin
            rx = int'(m_bw / 4 + m_bh / 4 + 2);
            if ($urandom_range(99) < 75)
            begin
                add_pixel(int'(m_cx) + $urandom_range(2 * rx) - rx,
                          int'(m_cy) + $urandom_range(2 * rx) - rx, $urandom);
            end
            else
                add_pixel($urandom_range(1023), $urandom_range(1023), $urandom);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_req        = 1'b0;
        cfg_req_idx    = '0;
        cfg_req_val    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        m_cx = 0;
        m_cy = 0;
        m_bw = 0;
        m_bh = 0;
        m_rate = 3277;
        repeat (2) @(posedge clk);
        #1;
        rst_n = 1'b1;
        @(posedge clk);

        // reset values: zero box, every pixel in place
        add_pixel(0, 0, 24'h000000);
        add_pixel(1023, 1023, 24'hFFFFFF);
        add_pixel(639, 479, 24'h123456);
        add_pixel(640, 480, 24'hABCDEF);
        drain();

        // typical box, pixel on the center and at the rim
        set_box(320, 240, 100, 80, 3277);
        add_pixel(320, 240, 24'h55AA55);
        add_pixel(345, 240, 24'h0F0F0F);
        add_pixel(320, 265, 24'hF0F0F0);
        add_pixel(295, 240, 24'h111111);
        add_pixel(320, 215, 24'h222222);
        add_pixel(300, 220, 24'h333333);
        add_pixel(340, 260, 24'h444444);
        add_pixel(0, 0, 24'h666666);
        drain();

        // extreme registers: corner center, full box, full twist
        set_box(1023, 1023, 1023, 1023, 65535);
        add_pixel(1023, 1023, 24'h777777);
        add_pixel(800, 900, 24'h888888);
        add_pixel(1000, 700, 24'h999999);
        add_pixel(1023, 800, 24'hAAAAAA);
        drain();
        set_box(0, 0, 1023, 0, 0);
        add_pixel(0, 0, 24'hBBBBBB);
        add_pixel(150, 0, 24'hCCCCCC);
        add_pixel(0, 150, 24'hDDDDDD);
        add_pixel(100, 100, 24'hEEEEEE);
        drain();

        // random phases, each with its own box and handshake pressure
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            if (ph == 7)
                set_box(0, 1023, 0, 1023, 65535);
            else
                set_box($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                        $urandom_range(1023), $urandom_range(65535));
            add_random(N_RANDOM / 8);
            drain();
        end

        $display("%0d pixels driven, %0d writes checked, %0d inside the swirl, %0d out of frame",
                 pixels_sent, writes_seen, inside_seen, outframe_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
rtl/spw_pkg.sv
rtl/spw_sqrt_cell.sv
rtl/spw_vec_cell.sv
rtl/spw_rot_cell.sv
rtl/swirl_pixel_warp.sv
tb/testbench.sv
